### hw/rtl/sensor_command_packet_framer_macros.svh
// Assertion helpers used by the framer top-level source.
`ifndef SENSOR_COMMAND_PACKET_FRAMER_MACROS_SVH
`define SENSOR_COMMAND_PACKET_FRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

### hw/rtl/scpf_pkg.sv
`timescale 1ns / 1ps

package scpf_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned SUM_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_WORD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_KIND    = 2'd2;

  localparam logic [15:0] START_WORD_RST     = 16'hEF01;
  localparam logic [31:0] DEVICE_ADDRESS_RST = 32'hFFFF_FFFF;
  localparam logic [7:0]  PACKET_KIND_RST    = 8'h01;

  localparam logic [LEN_W-1:0] LEN_OVERHEAD = 16'd2;

  // One request as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] csum;
  } scpf_entry_t;

  // Position of the next byte to send within one request.
  typedef enum logic [3:0] {
    PH_START_HI = 4'd0,
    PH_START_LO = 4'd1,
    PH_ADDR_3   = 4'd2,
    PH_ADDR_2   = 4'd3,
    PH_ADDR_1   = 4'd4,
    PH_ADDR_0   = 4'd5,
    PH_KIND     = 4'd6,
    PH_LEN_HI   = 4'd7,
    PH_LEN_LO   = 4'd8,
    PH_DATA     = 4'd9,
    PH_SUM_HI   = 4'd10,
    PH_SUM_LO   = 4'd11
  } scpf_phase_e;

endpackage

### hw/rtl/scpf_front.sv
`timescale 1ns / 1ps

module scpf_front import scpf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [8:0]  payload_count_i,
  input  logic [7:0]  packet_kind_i,
  output scpf_entry_t entry_o
);

  logic [SUM_W-1:0] running_sum_q, running_sum_d;
  logic [LEN_W-1:0] count_sat;
  logic [LEN_W-1:0] len;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W-1:0] new_sum;

  always_comb begin
    if ({8'd0, payload_count_i} > 17'(MAX_PAYLOAD)) begin
      count_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      count_sat = {7'd0, payload_count_i};
    end
    len = count_sat + LEN_OVERHEAD;
    if (first_byte_i) begin
      base_sum = {8'd0, len[15:8]} + {8'd0, len[7:0]} + {8'd0, packet_kind_i};
    end else begin
      base_sum = running_sum_q;
    end
    new_sum = base_sum + {8'd0, payload_byte_i};
    running_sum_d = last_byte_i ? '0 : new_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
    end else if (accept_i) begin
      running_sum_q <= running_sum_d;
    end
  end

  always_comb begin
    entry_o.data  = payload_byte_i;
    entry_o.first = first_byte_i;
    entry_o.last  = last_byte_i;
    entry_o.len   = len;
    entry_o.csum  = new_sum;
  end

endmodule

### hw/rtl/scpf_queue.sv
`timescale 1ns / 1ps

module scpf_queue import scpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  scpf_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output scpf_entry_t entry_o
);

  scpf_entry_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### hw/rtl/scpf_back.sv
`timescale 1ns / 1ps

module scpf_back import scpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] start_word_i,
  input  logic [31:0] device_address_i,
  input  logic [7:0]  packet_kind_i,
  input  logic        head_valid_i,
  input  scpf_entry_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  wire_byte_o,
  output logic        run_end_o,
  output logic        frame_end_o
);

  scpf_phase_e phase_q, phase_d, cur_phase;
  logic        active_q, active_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  wire_byte_q, wire_byte_d;
  logic        run_end_q, run_end_d;
  logic        frame_end_q, frame_end_d;
  logic        emit;
  logic        entry_done;

  always_comb begin
    if (active_q) begin
      cur_phase = phase_q;
    end else if (head_i.first) begin
      cur_phase = PH_START_HI;
    end else begin
      cur_phase = PH_DATA;
    end

    emit = head_valid_i && (!out_valid_q || !out_stall_i);

    unique case (cur_phase)
      PH_START_HI: wire_byte_d = start_word_i[15:8];
      PH_START_LO: wire_byte_d = start_word_i[7:0];
      PH_ADDR_3:   wire_byte_d = device_address_i[31:24];
      PH_ADDR_2:   wire_byte_d = device_address_i[23:16];
      PH_ADDR_1:   wire_byte_d = device_address_i[15:8];
      PH_ADDR_0:   wire_byte_d = device_address_i[7:0];
      PH_KIND:     wire_byte_d = packet_kind_i;
      PH_LEN_HI:   wire_byte_d = head_i.len[15:8];
      PH_LEN_LO:   wire_byte_d = head_i.len[7:0];
      PH_DATA:     wire_byte_d = head_i.data;
      PH_SUM_HI:   wire_byte_d = head_i.csum[15:8];
      PH_SUM_LO:   wire_byte_d = head_i.csum[7:0];
      default:     wire_byte_d = head_i.data;
    endcase

    entry_done  = ((cur_phase == PH_DATA) && !head_i.last) || (cur_phase == PH_SUM_LO);
    run_end_d   = entry_done;
    frame_end_d = (cur_phase == PH_SUM_LO);
    pop_o       = emit && entry_done;

    phase_d  = phase_q;
    active_d = active_q;
    if (emit) begin
      if (entry_done) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        phase_d  = scpf_phase_e'(cur_phase + 4'd1);
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START_HI;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      wire_byte_q <= wire_byte_d;
      run_end_q   <= run_end_d;
      frame_end_q <= frame_end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign wire_byte_o = wire_byte_q;
  assign run_end_o   = run_end_q;
  assign frame_end_o = frame_end_q;

endmodule

### hw/rtl/sensor_command_packet_framer.sv
// Frames command payload bytes into sensor packets. Each accepted request carries one payload
// byte; a request marked first is preceded by a nine-byte header (start word, address, packet
// kind, length) and a request marked last is followed by the two checksum bytes, so one request
// yields one to twelve output bytes. Requests are taken one per cycle into a two-entry queue
// while it is not full; the back end sends one byte per cycle while the receiver does not
// stall it. The back end's output, which the receiver's stall can hold, is the only limit
// on the rate. Configuration must be written only while no request is in flight.
`timescale 1ns / 1ps

`include "sensor_command_packet_framer_macros.svh"

module sensor_command_packet_framer import scpf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           payload_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  input  logic [8:0]           payload_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           wire_byte_o,
  output logic                 run_end_o,
  output logic                 frame_end_o
);

  logic [15:0] start_word_q;
  logic [31:0] device_address_q;
  logic [7:0]  packet_kind_q;
  logic        accept;
  logic        queue_full;
  logic        head_valid;
  logic        pop;
  scpf_entry_t front_entry;
  scpf_entry_t head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q     <= START_WORD_RST;
      device_address_q <= DEVICE_ADDRESS_RST;
      packet_kind_q    <= PACKET_KIND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_WORD:     start_word_q     <= cfg_wdata_i[15:0];
        CFG_DEVICE_ADDRESS: device_address_q <= cfg_wdata_i;
        CFG_PACKET_KIND:    packet_kind_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = queue_full;
  assign accept     = in_valid_i && !queue_full;

  scpf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .payload_byte_i (payload_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .payload_count_i(payload_count_i),
    .packet_kind_i  (packet_kind_q),
    .entry_o        (front_entry)
  );

  scpf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .entry_i(front_entry),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .entry_o(head_entry)
  );

  scpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_word_i    (start_word_q),
    .device_address_i(device_address_q),
    .packet_kind_i   (packet_kind_q),
    .head_valid_i    (head_valid),
    .head_i          (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .wire_byte_o     (wire_byte_o),
    .run_end_o       (run_end_o),
    .frame_end_o     (frame_end_o)
  );

  `SCPF_ASSERT_SAME(a_frame_end_closes_run, clk_i, rst_ni, out_valid_o && frame_end_o, run_end_o)
  `SCPF_ASSERT_SAME(a_stall_only_when_busy, clk_i, rst_ni, in_stall_o, head_valid)
  `SCPF_ASSERT_NEXT(a_pop_shows_run_end, clk_i, rst_ni, pop, out_valid_o && run_end_o)

endmodule

### test/scpf_stream_check.sv
`timescale 1ns / 1ps

module scpf_stream_check import scpf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           payload_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  input  logic [8:0]           payload_count_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           wire_byte_i,
  input  logic                 run_end_i,
  input  logic                 frame_end_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   bytes_checked_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       frame_end;
  } wire_beat_t;

  wire_beat_t  expected_beats_q[$];
  logic [15:0] start_word_m;
  logic [31:0] device_address_m;
  logic [7:0]  packet_kind_m;
  logic [15:0] frame_sum;
  wire_beat_t  got_beat;
  wire_beat_t  want_beat;
  int          mismatch_count;
  int          bytes_checked;

  function automatic wire_beat_t beat(input logic [7:0] data, input logic run_end,
                                      input logic frame_end);
    wire_beat_t b;
    b.data      = data;
    b.run_end   = run_end;
    b.frame_end = frame_end;
    return b;
  endfunction

  task automatic frame_request(input logic [7:0] data, input logic is_first,
                               input logic is_last, input logic [8:0] count);
    int unsigned clipped;
    logic [15:0] frame_len;
    if (is_first) begin
      clipped   = (count > MAX_PAYLOAD) ? MAX_PAYLOAD : count;
      frame_len = 16'(clipped + 2);
      expected_beats_q.push_back(beat(start_word_m[15:8], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(start_word_m[7:0], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(device_address_m[31:24], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(device_address_m[23:16], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(device_address_m[15:8], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(device_address_m[7:0], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(packet_kind_m, 1'b0, 1'b0));
      expected_beats_q.push_back(beat(frame_len[15:8], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(frame_len[7:0], 1'b0, 1'b0));
      frame_sum = 16'(frame_len[15:8]) + 16'(frame_len[7:0]) + 16'(packet_kind_m);
    end
    expected_beats_q.push_back(beat(data, !is_last, 1'b0));
    frame_sum = frame_sum + 16'(data);
    if (is_last) begin
      expected_beats_q.push_back(beat(frame_sum[15:8], 1'b0, 1'b0));
      expected_beats_q.push_back(beat(frame_sum[7:0], 1'b1, 1'b1));
      frame_sum = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_m     = START_WORD_RST;
      device_address_m = DEVICE_ADDRESS_RST;
      packet_kind_m    = PACKET_KIND_RST;
      frame_sum        = '0;
      mismatch_count   = 0;
      bytes_checked    = 0;
      expected_beats_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_WORD:     start_word_m     = cfg_wdata_i[15:0];
          CFG_DEVICE_ADDRESS: device_address_m = cfg_wdata_i;
          CFG_PACKET_KIND:    packet_kind_m    = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got_beat = beat(wire_byte_i, run_end_i, frame_end_i);
        bytes_checked++;
        if (expected_beats_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected byte %02h run_end %0b frame_end %0b", $time,
                     got_beat.data, got_beat.run_end, got_beat.frame_end);
          end
          mismatch_count++;
        end else begin
          want_beat = expected_beats_q.pop_front();
          if (got_beat !== want_beat) begin
            if (mismatch_count < 10) begin
              $display("%0t: expected byte %02h run_end %0b frame_end %0b, got %02h %0b %0b",
                       $time, want_beat.data, want_beat.run_end, want_beat.frame_end,
                       got_beat.data, got_beat.run_end, got_beat.frame_end);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        frame_request(payload_byte_i, first_byte_i, last_byte_i, payload_count_i);
      end
    end
    fail_count_o    <= mismatch_count;
    pending_o       <= expected_beats_q.size();
    bytes_checked_o <= bytes_checked;
  end

endmodule

### test/tb_sensor_command_packet_framer.sv
`timescale 1ns / 1ps

module tb_sensor_command_packet_framer import scpf_pkg::*;;

  localparam int unsigned MAX_PAYLOAD   = 256;
  localparam int unsigned PHASE_REQUESTS = 100;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_START_WORD;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           payload_byte  = '0;
  logic                 first_byte    = 1'b0;
  logic                 last_byte     = 1'b0;
  logic [8:0]           payload_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           wire_byte;
  logic                 run_end;
  logic                 frame_end;

  int fail_count;
  int beats_pending;
  int bytes_checked;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int requests_sent   = 0;
  int settings_loaded = 0;

  sensor_command_packet_framer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .payload_byte_i (payload_byte),
    .first_byte_i   (first_byte),
    .last_byte_i    (last_byte),
    .payload_count_i(payload_count),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .wire_byte_o    (wire_byte),
    .run_end_o      (run_end),
    .frame_end_o    (frame_end)
  );

  scpf_stream_check #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_stream_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .payload_byte_i (payload_byte),
    .first_byte_i   (first_byte),
    .last_byte_i    (last_byte),
    .payload_count_i(payload_count),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .wire_byte_i    (wire_byte),
    .run_end_i      (run_end),
    .frame_end_i    (frame_end),
    .fail_count_o   (fail_count),
    .pending_o      (beats_pending),
    .bytes_checked_o(bytes_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(input logic [7:0] data, input logic is_first,
                              input logic is_last, input logic [8:0] count);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    payload_byte  <= data;
    first_byte    <= is_first;
    last_byte     <= is_last;
    payload_count <= count;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
  endtask

  task automatic load_link_config(input logic [15:0] start_word, input logic [31:0] address,
                                  input logic [7:0] kind);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START_WORD;
    cfg_wdata <= {16'h0000, start_word};
    @(posedge clk);
    cfg_idx   <= CFG_DEVICE_ADDRESS;
    cfg_wdata <= address;
    @(posedge clk);
    cfg_idx   <= CFG_PACKET_KIND;
    cfg_wdata <= {24'h000000, kind};
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_packet();
    int unsigned n;
    logic [8:0]  count;
    n     = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
    count = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'(n);
    for (int unsigned i = 0; i < n; i++) begin
      send_request(8'($urandom_range(255)), i == 0, i == n - 1,
                   (i == 0) ? count : 9'($urandom_range(511)));
    end
  endtask

  initial begin
    #2_000_000;
    $display("[sensor_command_packet_framer] ERROR");
    $finish;
  end

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Loose bytes before any packet has been opened, then one-byte packets with edge-case counts and a short packet.
    send_request(8'h3C, 1'b0, 1'b0, 9'd0);
    send_request(8'hC3, 1'b0, 1'b1, 9'd0);
    send_request(8'h00, 1'b1, 1'b1, 9'd1);
    send_request(8'hFF, 1'b1, 1'b1, 9'd256);
    send_request(8'h5A, 1'b1, 1'b1, 9'd0);
    send_request(8'hA5, 1'b1, 1'b1, 9'd511);
    send_request(8'h81, 1'b1, 1'b1, 9'd257);
    send_request(8'h12, 1'b1, 1'b0, 9'd3);
    send_request(8'h34, 1'b0, 1'b0, 9'h1FF);
    send_request(8'h56, 1'b0, 1'b1, 9'd0);
    // The declared length disagrees with the bytes that follow.
    send_request(8'h77, 1'b1, 1'b0, 9'd5);
    send_request(8'h88, 1'b0, 1'b1, 9'd0);
    // A new packet opens before the previous one was closed.
    send_request(8'h11, 1'b1, 1'b0, 9'd4);
    send_request(8'h22, 1'b1, 1'b0, 9'd2);
    send_request(8'h33, 1'b0, 1'b1, 9'd0);

    wait_drained();
    load_link_config(16'h0000, 32'h0000_0000, 8'h00);
    send_request(8'hFF, 1'b1, 1'b1, 9'd256);
    send_request(8'h01, 1'b1, 1'b0, 9'd2);
    send_request(8'hFE, 1'b0, 1'b1, 9'd0);

    wait_drained();
    load_link_config(16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(8'h00, 1'b1, 1'b1, 9'd0);
    send_request(8'hFF, 1'b1, 1'b0, 9'd2);
    send_request(8'hFF, 1'b0, 1'b1, 9'd0);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase == 0) begin
        load_link_config(START_WORD_RST, DEVICE_ADDRESS_RST, PACKET_KIND_RST);
      end else begin
        load_link_config(16'($urandom_range(65535)), $urandom, 8'($urandom_range(255)));
      end
      goal = requests_sent + PHASE_REQUESTS;
      while (requests_sent < goal) begin
        if ($urandom_range(9) < 8) begin
          send_packet();
        end else begin
          send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       9'($urandom_range(511)));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d checked output bytes under %0d register settings,",
             requests_sent, bytes_checked, settings_loaded);
    $display("with steady traffic, sender gaps, receiver stalls and both together.");
    if (fail_count == 0 && beats_pending == 0) begin
      $display("[sensor_command_packet_framer] OK");
    end else begin
      $display("[sensor_command_packet_framer] ERROR");
    end
    $finish;
  end

endmodule
